[rtl/core/kfc_pkg.sv]
package kfc_pkg;

  localparam int unsigned KwSlots  = 10;
  localparam int unsigned KwMaxLen = 8;
  localparam int unsigned KwIdxW   = 4;
  localparam int unsigned CountW   = 32;
  localparam int unsigned LenW     = 7;
  localparam int unsigned CharW    = 8;

  // keyword text, table order; positions past the keyword length are zero
  localparam logic [CharW-1:0] KwText [KwSlots][KwMaxLen] = '{
    '{"a", "u", "t", "o", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
    '{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00},
    '{"c", "o", "n", "t", "i", "n", "u", "e"},
    '{"d", "e", "f", "a", "u", "l", "t", 8'h00},
    '{"u", "n", "s", "i", "g", "n", "e", "d"},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
  };

  localparam logic [LenW-1:0] KwLen [KwSlots] = '{
    7'd4, 7'd5, 7'd4, 7'd4, 7'd5, 7'd8, 7'd7, 7'd8, 7'd4, 7'd5
  };

  // word-close event passed from the word tracker to the tally
  typedef struct packed {
    logic              valid;
    logic              eoi;
    logic              hit;
    logic [KwIdxW-1:0] idx;
  } kfc_event_t;

  function automatic logic is_letter(logic [CharW-1:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(logic [CharW-1:0] c);
    return (c >= "0" && c <= "9");
  endfunction

endpackage

[rtl/core/kfc_word.sv]
module kfc_word #(
  parameter int unsigned NumKw   = 10,
  parameter int unsigned MaxWord = 100
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_fire_i,
  input  logic [kfc_pkg::CharW-1:0]   ch_i,
  input  logic                        eoi_i,
  input  logic                        ev_ready_i,
  output kfc_pkg::kfc_event_t         ev_o
);
  import kfc_pkg::*;

  logic             in_word_q, in_word_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [NumKw-1:0] mask_q, mask_d;
  kfc_event_t       ev_q, ev_d;

  logic             alnum, letter;
  logic [NumKw-1:0] base_mask, tk_mask, cl_mask;
  logic [LenW-1:0]  base_len, tk_len, cl_len;
  logic             cl_valid, hit;
  logic [KwIdxW-1:0] hit_idx;

  always_comb begin
    letter    = is_letter(ch_i);
    alnum     = letter || is_digit(ch_i);
    base_mask = in_word_q ? mask_q : '1;
    base_len  = in_word_q ? len_q : '0;
    tk_len    = base_len + LenW'(1);
    for (int k = 0; k < NumKw; k++) begin
      tk_mask[k] = base_mask[k] && (base_len < KwLen[k]) &&
                   (KwText[k][base_len[2:0]] == ch_i);
    end
  end

  always_comb begin
    in_word_d = in_word_q;
    len_d     = len_q;
    mask_d    = mask_q;
    cl_valid  = 1'b0;
    cl_mask   = mask_q;
    cl_len    = len_q;
    priority if (eoi_i) begin
      cl_valid  = in_word_q;
      in_word_d = 1'b0;
      len_d     = '0;
      mask_d    = '1;
    end else if (in_word_q && !alnum) begin
      cl_valid  = 1'b1;
      in_word_d = 1'b0;
      len_d     = '0;
      mask_d    = '1;
    end else if ((in_word_q && alnum) || (!in_word_q && letter)) begin
      if (tk_len >= LenW'(MaxWord)) begin
        cl_valid  = 1'b1;
        cl_mask   = tk_mask;
        cl_len    = tk_len;
        in_word_d = 1'b0;
        len_d     = '0;
        mask_d    = '1;
      end else begin
        in_word_d = 1'b1;
        len_d     = tk_len;
        mask_d    = tk_mask;
      end
    end else begin
      in_word_d = in_word_q;
    end
  end

  // first matching keyword wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (cl_valid && cl_mask[k] && (cl_len == KwLen[k])) begin
        hit     = 1'b1;
        hit_idx = KwIdxW'(k);
      end
    end
  end

  always_comb begin
    ev_d = ev_q;
    if (in_fire_i) begin
      ev_d.valid = eoi_i || hit;
      ev_d.eoi   = eoi_i;
      ev_d.hit   = hit;
      ev_d.idx   = hit_idx;
    end else if (ev_ready_i) begin
      ev_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q <= 1'b0;
      len_q     <= '0;
      mask_q    <= '1;
      ev_q      <= '0;
    end else begin
      if (in_fire_i) begin
        in_word_q <= in_word_d;
        len_q     <= len_d;
        mask_q    <= mask_d;
      end
      ev_q <= ev_d;
    end
  end

  assign ev_o = ev_q;

endmodule

[rtl/core/kfc_tally.sv]
module kfc_tally #(
  parameter int unsigned NumKw = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kfc_pkg::kfc_event_t          ev_i,
  output logic                         ev_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [kfc_pkg::KwIdxW-1:0]   keyword_index_o,
  output logic [kfc_pkg::CountW-1:0]   keyword_count_o,
  output logic                         last_entry_o
);
  import kfc_pkg::*;

  localparam int unsigned AddrW = (NumKw > 1) ? $clog2(NumKw) : 1;

  logic [CountW-1:0] cnt_q  [NumKw];
  logic [CountW-1:0] cnt_d  [NumKw];
  logic [CountW-1:0] dump_q [NumKw];
  logic              busy_q, busy_d;
  logic [KwIdxW-1:0] idx_q, idx_d;
  logic              out_fire, last, dump_free, ev_take, load;

  assign last       = (idx_q == KwIdxW'(NumKw - 1));
  assign out_fire   = busy_q && out_ready_i;
  assign dump_free  = !busy_q || (out_fire && last);
  assign ev_ready_o = !ev_i.eoi || dump_free;
  assign ev_take    = ev_i.valid && ev_ready_o;
  assign load       = ev_take && ev_i.eoi;

  // saturating bump of the closed keyword
  always_comb begin
    for (int k = 0; k < NumKw; k++) begin
      cnt_d[k] = cnt_q[k];
      if (ev_i.hit && (ev_i.idx == KwIdxW'(k)) && (cnt_q[k] != '1)) begin
        cnt_d[k] = cnt_q[k] + CountW'(1);
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (out_fire) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + KwIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      for (int k = 0; k < NumKw; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (ev_take) begin
        for (int k = 0; k < NumKw; k++) begin
          cnt_q[k] <= ev_i.eoi ? '0 : cnt_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int k = 0; k < NumKw; k++) begin
        dump_q[k] <= cnt_d[k];
      end
    end
  end

  assign out_valid_o     = busy_q;
  assign keyword_index_o = idx_q;
  assign keyword_count_o = dump_q[idx_q[AddrW-1:0]];
  assign last_entry_o    = last;

endmodule

[rtl/core/keyword_frequency_counter.sv]
// Keyword frequency counter.
// Input channel (in_valid_i/in_ready_o) carries one ASCII character per
// request in ch_i. Words start with a letter and run through letters and
// digits; each word equal to one of the keywords bumps a saturating count.
// A request with end_of_input_i set closes the open word and starts a dump
// of NUM_KEYWORDS entries on the output channel (out_valid_o/out_ready_i):
// keyword_index_o, keyword_count_o, last_entry_o, zero counts included.
// The counts restart from zero for the following characters.
// Throughput: one character per cycle while in_ready_o is high. The dump
// runs from a snapshot buffer, so characters keep flowing meanwhile; a
// second end-of-input request waits until the last dump entry is taken.
// An accepted end-of-input request is held in the word tracker event
// register, then its counts are captured in the snapshot buffer, which
// makes the first dump entry valid; a busy dump can hold it in between.
// A stalled receiver holds the current entry; once the next end-of-input
// backs up, in_ready_o drops.
// Reset clears the word state and all counts; nothing is output.
module keyword_frequency_counter #(
  parameter int unsigned MAX_WORD     = 100,
  parameter int unsigned NUM_KEYWORDS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [kfc_pkg::CharW-1:0]    ch_i,
  input  logic                         end_of_input_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [kfc_pkg::KwIdxW-1:0]   keyword_index_o,
  output logic [kfc_pkg::CountW-1:0]   keyword_count_o,
  output logic                         last_entry_o
);
  import kfc_pkg::*;

  kfc_event_t ev;
  logic       ev_ready, in_fire;

  assign in_ready_o = !ev.valid || ev_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  kfc_word #(
    .NumKw   (NUM_KEYWORDS),
    .MaxWord (MAX_WORD)
  ) u_word (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .ch_i       (ch_i),
    .eoi_i      (end_of_input_i),
    .ev_ready_i (ev_ready),
    .ev_o       (ev)
  );

  kfc_tally #(
    .NumKw (NUM_KEYWORDS)
  ) u_tally (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ev_i            (ev),
    .ev_ready_o      (ev_ready),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .keyword_index_o (keyword_index_o),
    .keyword_count_o (keyword_count_o),
    .last_entry_o    (last_entry_o)
  );

endmodule
